// ===== rtl/core/fcsc_pkg.sv =====
// Shared types and constants for the FASTA composition and scan-count block.
// Holds the payload structs, parse phases, register indexes and characters.
// No dependencies.
package fcsc_pkg;

  // Default width of the per-sequence length counter
  localparam int unsigned LENGTH_BITS_DEF = 32;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_FIRST_SEQ  = 3'd0;
  localparam cfg_idx_t REG_SEQ_COUNT  = 3'd1;
  localparam cfg_idx_t REG_START_OFF  = 3'd2;
  localparam cfg_idx_t REG_WINDOW_LEN = 3'd3;
  localparam cfg_idx_t REG_MASK_LEN   = 3'd4;
  localparam cfg_idx_t REG_SKIP_ANNOT = 3'd5;

  // Characters that steer the parser and the base counters
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_U  = 8'h55;

  typedef enum logic [2:0] {
    PH_PREAMBLE,
    PH_HEADER,
    PH_LINESTART,
    PH_SEQ,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sequence_length;
    logic [31:0] scan_count;
    logic [47:0] total_scan;
    logic [39:0] count_a;
    logic [39:0] count_c;
    logic [39:0] count_g;
    logic [39:0] count_t;
    logic [23:0] sequences_done;
    logic        last;
  } res_item_t;

  // Settings seen by the parser, with the scan bounds folded in
  typedef struct packed {
    logic [15:0] first_eff;  // first processed index after clamping
    logic [23:0] seq_count;
    logic [32:0] lo_bound;   // start_offset + mask_length - 1
    logic [32:0] hi_bound;   // start_offset + window_length
  } cfg_view_t;

endpackage

// ===== rtl/core/fasta_composition_and_scan_count.sv =====
// Top level of the FASTA composition and scan-count block.
// Parses the byte stream, counts bases and emits a result per selected sequence.
// Depends on fcsc_pkg and fcsc_cfg.
//
//   port group  direction  handshake              payload
//   in_*        input      in_valid / in_stall    fcsc_pkg::in_item_t
//   out_*       output     out_valid / out_stall  fcsc_pkg::res_item_t
//   cfg_*       input      cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// One byte per cycle unless in_stall is high; each result is registered to out_*.
// The parse, count and scan bound logic sits between the state registers and
// a two-entry result buffer (output register plus skid register).
// in_stall rises only while both result entries are full.
// rst_n is synchronous; configuration writes are always accepted (cfg_ready high).
module fasta_composition_and_scan_count #(
  parameter int unsigned LENGTH_BITS = fcsc_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcsc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fcsc_pkg::res_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  fcsc_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import fcsc_pkg::*;

  // Width of the scan bound arithmetic
  localparam int unsigned CW = ((LENGTH_BITS > 33) ? LENGTH_BITS : 33) + 1;

  cfg_view_t cfg_view;

  phase_t                 phase_r, phase_nxt;
  logic [23:0]            idx_r, idx_nxt;
  logic                   sel_r, sel_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [39:0]            cnt_r [4];
  logic [39:0]            cnt_nxt [4];
  logic [47:0]            total_r, total_nxt;
  logic [23:0]            proc_r, proc_nxt;

  res_item_t out_r, skid_r, res;
  logic      out_v_r, skid_v_r;
  logic      res_fire;

  logic        in_acc, take;
  logic [7:0]  c, cu;
  logic        alpha;
  logic        do_count, do_finish, do_begin, last_v;
  logic [CW-1:0] len_ext, lmin;
  logic [31:0] scan_val, len_sat;
  logic [48:0] total_sum;
  logic [47:0] total_fin;
  logic [23:0] proc_inc, idx_inc;

  fcsc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg_view (cfg_view)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign in_acc    = in_valid && !in_stall;
  assign take      = out_v_r && !out_stall;

  // Fold case and classify the byte
  assign c     = in_data.data_byte;
  assign alpha = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign cu    = c & 8'hDF;

  // Scan count: min(offset + window, length) - (offset + mask - 1), floored at zero
  assign len_ext  = CW'(len_r);
  assign lmin     = (len_ext < CW'(cfg_view.hi_bound)) ? len_ext : CW'(cfg_view.hi_bound);
  assign scan_val = (lmin > CW'(cfg_view.lo_bound)) ?
                    32'(lmin - CW'(cfg_view.lo_bound)) : 32'd0;
  assign len_sat  = (|len_ext[CW-1:32]) ? 32'hFFFF_FFFF : len_ext[31:0];

  assign total_sum = {1'b0, total_r} + {17'd0, scan_val};
  assign total_fin = total_sum[48] ? 48'hFFFF_FFFF_FFFF : total_sum[47:0];
  assign proc_inc  = (&proc_r) ? proc_r : proc_r + 24'd1;
  assign idx_inc   = (&idx_r) ? idx_r : idx_r + 24'd1;

  // Parse one byte, update the counters and build the result
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    sel_nxt   = sel_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    proc_nxt  = proc_r;
    do_count  = 1'b0;
    do_finish = 1'b0;
    do_begin  = 1'b0;
    last_v    = 1'b0;
    res_fire  = 1'b0;
    res       = '0;

    if (in_acc && (phase_r != PH_IDLE)) begin
      if (in_data.end_of_file) begin
        do_finish = 1'b1;
      end else begin
        case (phase_r)
          PH_PREAMBLE: begin
            if (c == CH_GT) begin
              do_begin  = 1'b1;
              phase_nxt = PH_HEADER;
            end
          end
          PH_HEADER: begin
            if (c == CH_NL) phase_nxt = PH_LINESTART;
          end
          PH_LINESTART: begin
            if (c == CH_GT) begin
              phase_nxt = PH_HEADER;
            end else begin
              phase_nxt = PH_SEQ;
              do_count  = 1'b1;
            end
          end
          PH_SEQ: begin
            if (c == CH_GT) begin
              do_finish = 1'b1;
              do_begin  = 1'b1;
              phase_nxt = PH_HEADER;
            end else begin
              do_count = 1'b1;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end

    // Count letters of a selected sequence
    if (do_count && sel_r && alpha) begin
      len_nxt = (&len_r) ? len_r : len_r + LENGTH_BITS'(1);
      if (cu == CH_A) begin
        cnt_nxt[0] = (&cnt_r[0]) ? cnt_r[0] : cnt_r[0] + 40'd1;
      end else if (cu == CH_C) begin
        cnt_nxt[1] = (&cnt_r[1]) ? cnt_r[1] : cnt_r[1] + 40'd1;
      end else if (cu == CH_G) begin
        cnt_nxt[2] = (&cnt_r[2]) ? cnt_r[2] : cnt_r[2] + 40'd1;
      end else if ((cu == CH_T) || (cu == CH_U)) begin
        cnt_nxt[3] = (&cnt_r[3]) ? cnt_r[3] : cnt_r[3] + 40'd1;
      end
    end

    // Close the current sequence
    if (do_finish) begin
      if (sel_r) begin
        total_nxt = total_fin;
        proc_nxt  = proc_inc;
        last_v    = in_data.end_of_file || (proc_inc >= cfg_view.seq_count);
        res_fire  = 1'b1;
        res.sequence_length = len_sat;
        res.scan_count      = scan_val;
      end else if (in_data.end_of_file) begin
        last_v   = 1'b1;
        res_fire = 1'b1;
      end
      sel_nxt = 1'b0;
      if (last_v) begin
        phase_nxt = PH_IDLE;
        do_begin  = 1'b0;
      end
    end

    res.total_scan     = total_nxt;
    res.count_a        = cnt_r[0];
    res.count_c        = cnt_r[1];
    res.count_g        = cnt_r[2];
    res.count_t        = cnt_r[3];
    res.sequences_done = proc_nxt;
    res.last           = last_v;

    // Open a header block and decide whether its sequence is processed
    if (do_begin) begin
      idx_nxt = idx_inc;
      sel_nxt = (idx_inc >= {8'd0, cfg_view.first_eff}) && (proc_nxt < cfg_view.seq_count);
      len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREAMBLE;
      idx_r   <= '0;
      sel_r   <= 1'b0;
      len_r   <= '0;
      cnt_r   <= '{default: '0};
      total_r <= '0;
      proc_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      sel_r   <= sel_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      proc_r  <= proc_nxt;
    end
  end

  // Result buffer: drain the skid entry first, park a new result there on a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || take) begin
      out_v_r <= res_fire;
    end else if (res_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) out_r <= skid_r;
    end else if (!out_v_r || take) begin
      if (res_fire) out_r <= res;
    end else if (res_fire) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/fcsc_cfg.sv =====
// Configuration registers of the FASTA composition block.
// Folds offset, window and mask into two scan bounds on every write.
// Depends on fcsc_pkg.
module fcsc_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  fcsc_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]        cfg_wdata,
  output fcsc_pkg::cfg_view_t cfg_view
);
  import fcsc_pkg::*;

  logic [15:0] first_r, first_nxt;
  logic [23:0] count_r, count_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] win_r, win_nxt;
  logic [15:0] kmask_r, kmask_nxt;
  logic        skip_r, skip_nxt;
  logic [32:0] lo_r, lo_nxt;
  logic [32:0] hi_r, hi_nxt;
  logic [15:0] first_eff;

  // Decode the write transaction and refresh the scan bounds
  always_comb begin
    first_nxt = first_r;
    count_nxt = count_r;
    off_nxt   = off_r;
    win_nxt   = win_r;
    kmask_nxt = kmask_r;
    skip_nxt  = skip_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FIRST_SEQ:  first_nxt = cfg_wdata[15:0];
        REG_SEQ_COUNT:  count_nxt = cfg_wdata[23:0];
        REG_START_OFF:  off_nxt   = cfg_wdata;
        REG_WINDOW_LEN: win_nxt   = cfg_wdata;
        REG_MASK_LEN: begin
          // a zero mask behaves as a mask of one
          kmask_nxt = (cfg_wdata[15:0] == 16'd0) ? 16'd0 : cfg_wdata[15:0] - 16'd1;
        end
        REG_SKIP_ANNOT: skip_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end
    lo_nxt = {1'b0, off_nxt} + {17'd0, kmask_nxt};
    hi_nxt = {1'b0, off_nxt} + {1'b0, win_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 16'd1;
      count_r <= '1;
      off_r   <= '0;
      win_r   <= '1;
      kmask_r <= '0;
      skip_r  <= 1'b0;
      lo_r    <= '0;
      hi_r    <= {1'b0, 32'hFFFF_FFFF};
    end else begin
      first_r <= first_nxt;
      count_r <= count_nxt;
      off_r   <= off_nxt;
      win_r   <= win_nxt;
      kmask_r <= kmask_nxt;
      skip_r  <= skip_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
    end
  end

  // Raise the first index to one, and to two when the annotation is skipped
  always_comb begin
    first_eff = (first_r == 16'd0) ? 16'd1 : first_r;
    if (skip_r && (first_eff < 16'd2)) begin
      first_eff = 16'd2;
    end
  end

  assign cfg_view.first_eff = first_eff;
  assign cfg_view.seq_count = count_r;
  assign cfg_view.lo_bound  = lo_r;
  assign cfg_view.hi_bound  = hi_r;

endmodule

// ===== rtl/core/fcsc_checker.sv =====
// Port-level checks for the FASTA composition and scan-count block.
// Attached to the top level by the bind statement at the end of the file.
// Depends on fcsc_pkg.
module fcsc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input fcsc_pkg::res_item_t out_data
);
  import fcsc_pkg::*;

  // Input back-pressure only while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall raised with no result pending");

  // Nothing follows the final result
  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid)
    else $error("result after the final transaction");

  // The clamp never gives more positions than letters
  a_scan_within_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.scan_count <= out_data.sequence_length)
    else $error("scan_count exceeds sequence_length");

  // The running total includes this sequence's scan count
  a_total_covers_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.total_scan >= {16'd0, out_data.scan_count})
    else $error("total_scan below scan_count");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind fasta_composition_and_scan_count fcsc_checker u_fcsc_checker (.*);
